@@ src/chks_pkg.sv @@
package chks_pkg;

    localparam int SLOTS = 128;                 // power of two: index is the low hash bits
    localparam int IDX_W = $clog2(SLOTS);
    localparam int KEY_W = 32;
    localparam int KICK_W = 7;

    localparam logic [KEY_W-1:0] MIX_A = 32'h045d_9f3b;
    localparam logic [KEY_W-1:0] MIX_B = 32'h3335_b369;

    localparam logic [KICK_W-1:0] KICKS_RESET = 7'd64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic             start;
        logic             sel_b;    // 0: first-table mix, 1: second-table mix
        logic [KEY_W-1:0] key;
    } hash_req_t;

    typedef struct packed {
        logic             wr;       // write key and set valid
        logic             clr;      // clear valid
        logic [IDX_W-1:0] addr;
    } tbl_ctrl_t;

    function automatic logic [KEY_W-1:0] fold16(input logic [KEY_W-1:0] x);
        return (x >> 16) ^ x;
    endfunction

endpackage

@@ src/cuckoo_hash_key_set.sv @@
// Channel   Direction  Signals                              Contents
// --------  ---------  -----------------------------------  ------------------------------
// s_axis    in         s_axis_tvalid/tready/tdata/tuser     command (tuser), key (tdata)
// m_axis    out        m_axis_tvalid/tready/tdata/tuser     status (tuser), dropped_key
// cfg       in         cfg_valid/cfg_ready/cfg_data         eviction round limit (7 bits)
//
// Flow: one command at a time through one shared multiply-xorshift unit and a registered
// table read. Lookup, remove and insert of a present key hash the key for both tables,
// read both tables and check for a hit; the reserved code goes straight to a miss result.
// An insert of an absent key walks eviction rounds, each of which hashes the key in hand
// for the first table (not in the first round, whose first-table index is already known),
// places it there and sends the evicted key on to its second-table slot.
// Reset clears the valid bits of both tables at once and sets the eviction limit to 64.
// A finished result waits in the output register; the next command and a limit write are
// accepted as soon as the sequencer is idle, and the sequencer holds in its done state
// only while an older result is still untaken.
module cuckoo_hash_key_set
    import chks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,       // [31:0] key
    input  logic [1:0]  s_axis_tuser,       // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,       // [31:0] dropped_key
    output logic [1:0]  m_axis_tuser,       // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data            // [6:0] eviction round limit
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_HASH_A   = 12'b0000_0000_0010,
        ST_HASH_B   = 12'b0000_0000_0100,
        ST_LOOK_RD  = 12'b0000_0000_1000,
        ST_LOOK_CHK = 12'b0000_0001_0000,
        ST_K1_HASH  = 12'b0000_0010_0000,
        ST_K1_RD    = 12'b0000_0100_0000,
        ST_K1_CHK   = 12'b0000_1000_0000,
        ST_K2_HASH  = 12'b0001_0000_0000,
        ST_K2_RD    = 12'b0010_0000_0000,
        ST_K2_CHK   = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;       // command key
    logic [KEY_W-1:0]  cur_reg, cur_next;       // key in hand during the eviction walk
    logic [IDX_W-1:0]  idx_a_reg, idx_a_next;
    logic [IDX_W-1:0]  idx_b_reg, idx_b_next;
    logic [KICK_W-1:0] round_reg, round_next;
    logic [KICK_W-1:0] kicks_reg, kicks_next;
    logic [1:0]        res_stat_reg, res_stat_next;
    logic [KEY_W-1:0]  res_drop_reg, res_drop_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_stat_reg, out_stat_next;
    logic [KEY_W-1:0]  out_drop_reg, out_drop_next;

    hash_req_t         hreq;
    logic              hdone;
    logic [IDX_W-1:0]  hidx;
    tbl_ctrl_t         t0_ctrl, t1_ctrl;
    logic [KEY_W-1:0]  t0_key, t1_key;
    logic              t0_vld, t1_vld;
    logic [KEY_W-1:0]  wr_key;
    logic              hit0, hit1;
    logic              in_xfer;
    logic [KICK_W-1:0] round_inc;

    chks_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .done  (hdone),
        .idx   (hidx)
    );

    chks_table u_tbl0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (t0_ctrl),
        .wr_key   (wr_key),
        .rd_key   (t0_key),
        .rd_valid (t0_vld)
    );

    chks_table u_tbl1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (t1_ctrl),
        .wr_key   (wr_key),
        .rd_key   (t1_key),
        .rd_valid (t1_vld)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // take a new limit only between commands
    assign cfg_ready     = (state_reg == ST_IDLE);

    assign hit0      = t0_vld && (t0_key == key_reg);
    assign hit1      = t1_vld && (t1_key == key_reg);
    assign round_inc = round_reg + 7'd1;
    assign wr_key    = cur_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        round_next     = round_reg;
        kicks_next     = kicks_reg;
        res_stat_next  = res_stat_reg;
        res_drop_next  = res_drop_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_drop_next  = out_drop_reg;

        hreq.start = 1'b0;
        hreq.sel_b = 1'b0;
        hreq.key   = key_reg;

        // table addresses always come from the index registers
        t0_ctrl.wr   = 1'b0;
        t0_ctrl.clr  = 1'b0;
        t0_ctrl.addr = idx_a_reg;
        t1_ctrl.wr   = 1'b0;
        t1_ctrl.clr  = 1'b0;
        t1_ctrl.addr = idx_b_reg;

        if (cfg_valid && cfg_ready)
        begin
            kicks_next = cfg_data;
        end

        // drop the shown result once taken
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next      = s_axis_tuser;
                    key_next      = s_axis_tdata;
                    cur_next      = s_axis_tdata;
                    round_next    = '0;
                    res_drop_next = '0;
                    if (s_axis_tuser inside {CMD_INSERT, CMD_REMOVE, CMD_LOOKUP})
                    begin
                        hreq.start = 1'b1;
                        hreq.key   = s_axis_tdata;
                        state_next = ST_HASH_A;
                    end
                    else
                    begin
                        res_stat_next = STAT_MISS;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_HASH_A:
            begin
                if (hdone)
                begin
                    idx_a_next = hidx;
                    hreq.start = 1'b1;
                    hreq.sel_b = 1'b1;
                    hreq.key   = key_reg;
                    state_next = ST_HASH_B;
                end
            end
            ST_HASH_B:
            begin
                if (hdone)
                begin
                    idx_b_next = hidx;
                    state_next = ST_LOOK_RD;
                end
            end
            ST_LOOK_RD:
            begin
                state_next = ST_LOOK_CHK;
            end
            ST_LOOK_CHK:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_LOOKUP:
                    begin
                        res_stat_next = (hit0 || hit1) ? STAT_OK : STAT_MISS;
                    end
                    CMD_REMOVE:
                    begin
                        res_stat_next = (hit0 || hit1) ? STAT_OK : STAT_MISS;
                        t0_ctrl.clr   = hit0;
                        t1_ctrl.clr   = !hit0 && hit1;
                    end
                    default:
                    begin
                        // insert: present key changes nothing
                        if (hit0 || hit1)
                        begin
                            res_stat_next = STAT_OK;
                        end
                        else if (kicks_reg == '0)
                        begin
                            res_stat_next = STAT_FULL;
                            res_drop_next = key_reg;
                        end
                        else
                        begin
                            // first-table index of the key is already known
                            state_next = ST_K1_RD;
                        end
                    end
                endcase
            end
            ST_K1_HASH:
            begin
                if (hdone)
                begin
                    idx_a_next = hidx;
                    state_next = ST_K1_RD;
                end
            end
            ST_K1_RD:
            begin
                state_next = ST_K1_CHK;
            end
            ST_K1_CHK:
            begin
                t0_ctrl.wr = 1'b1;
                if (!t0_vld)
                begin
                    res_stat_next = STAT_OK;
                    state_next    = ST_DONE;
                end
                else
                begin
                    // swap: evicted key goes on to its second-table slot
                    cur_next   = t0_key;
                    hreq.start = 1'b1;
                    hreq.sel_b = 1'b1;
                    hreq.key   = t0_key;
                    state_next = ST_K2_HASH;
                end
            end
            ST_K2_HASH:
            begin
                if (hdone)
                begin
                    idx_b_next = hidx;
                    state_next = ST_K2_RD;
                end
            end
            ST_K2_RD:
            begin
                state_next = ST_K2_CHK;
            end
            ST_K2_CHK:
            begin
                t1_ctrl.wr = 1'b1;
                if (!t1_vld)
                begin
                    res_stat_next = STAT_OK;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cur_next   = t1_key;
                    round_next = round_inc;
                    if (round_inc == kicks_reg)
                    begin
                        res_stat_next = STAT_FULL;
                        res_drop_next = t1_key;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        hreq.start = 1'b1;
                        hreq.key   = t1_key;
                        state_next = ST_K1_HASH;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_axis_tvalid || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_drop_next  = res_drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kicks_reg     <= KICKS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kicks_reg     <= kicks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        idx_a_reg    <= idx_a_next;
        idx_b_reg    <= idx_b_next;
        round_reg    <= round_next;
        res_stat_reg <= res_stat_next;
        res_drop_reg <= res_drop_next;
        out_stat_reg <= out_stat_next;
        out_drop_reg <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tdata  = out_drop_reg;

endmodule

@@ src/chks_hash.sv @@
module chks_hash
    import chks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  hash_req_t        req,
    output logic             done,
    output logic [IDX_W-1:0] idx
);

    logic [KEY_W-1:0] x_reg, x_next;
    logic [KEY_W-1:0] mul_reg, mul_next;
    logic             busy_reg, busy_next;
    logic             step_reg, step_next;
    logic             done_reg, done_next;
    logic [KEY_W-1:0] folded;
    logic [KEY_W-1:0] prod;
    logic [KEY_W-1:0] mixed;

    // one shared multiplier, used twice per hash
    assign folded = fold16(x_reg);
    assign prod   = folded * mul_reg;
    assign mixed  = fold16(x_reg);

    always_comb
    begin
        x_next    = x_reg;
        mul_next  = mul_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = req.key;
            mul_next  = req.sel_b ? MIX_B : MIX_A;
            busy_next = 1'b1;
            step_next = 1'b0;
        end
        else if (busy_reg)
        begin
            x_next = prod;
            if (step_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        mul_reg <= mul_next;
    end

    assign done = done_reg;
    assign idx  = mixed[IDX_W-1:0];

endmodule

@@ src/chks_table.sv @@
module chks_table
    import chks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_ctrl_t        ctrl,
    input  logic [KEY_W-1:0] wr_key,
    output logic [KEY_W-1:0] rd_key,
    output logic             rd_valid
);

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic             rd_valid_reg;

    // key store: one write, one registered read at the same address
    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            key_mem[ctrl.addr] <= wr_key;
        end
        rd_key_reg <= key_mem[ctrl.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr)
            begin
                valid_reg[ctrl.addr] <= 1'b1;
            end
            else if (ctrl.clr)
            begin
                valid_reg[ctrl.addr] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[ctrl.addr];
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
    import chks_pkg::*;
();

    // Reserved command code: the block must answer it as a miss and touch nothing
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int IDLE_PCT    = 21;      // percent of cycles each side idles
    localparam int STALL_LIMIT = 20000;   // cycles with no transfer before giving up
    localparam int LONG_HOLD   = 300;     // one long receiver hold-off
    localparam int HOLD_AT     = 500;     // replies seen before the long hold-off starts
    localparam int SETTLE      = 40;      // quiet cycles before a register write and at the end
    localparam int POOL_CAP    = 120;     // keep the live key set near half load
    localparam int PHASES      = 6;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] dropped;
    } reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;          // [31:0] key
    logic [1:0]        s_axis_tuser = CMD_LOOKUP;  // [1:0] command
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;               // [31:0] dropped_key
    logic [1:0]        m_axis_tuser;               // [1:0] status
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KICK_W-1:0] cfg_data = '0;

    cuckoo_hash_key_set uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of both cuckoo tables and the eviction limit
    logic [KEY_W-1:0]  shadow_key   [2][SLOTS];
    logic              shadow_valid [2][SLOTS];
    logic [KICK_W-1:0] kick_limit;

    request_t          pending_requests[$];   // commands not yet offered to the block
    reply_t            pending_replies[$];    // predicted replies, oldest first
    logic [KEY_W-1:0]  live_keys[$];          // keys the stimulus believes are stored

    logic              calm = 1'b0;           // set: neither side idles
    logic              req_taken = 1'b0;      // command transfer at the last rising edge
    int                stall_cycles = 0;
    int                replies_seen = 0;
    int                mismatches = 0;
    int                hold_left = 0;
    logic              hold_done = 1'b0;
    int                cfg_writes = 0;
    int                cmd_count[4] = '{0, 0, 0, 0};
    int                status_count[4] = '{0, 0, 0, 0};

    int phase_kicks[PHASES] = '{1, 127, 0, 64, 5, 2};
    int phase_items[PHASES] = '{300, 300, 40, 320, 300, 300};

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Multiply-xorshift mix, reduced to a slot index (low bits, SLOTS is a power of two)
    function automatic logic [IDX_W-1:0] slot_hash(input logic [KEY_W-1:0] k,
                                                   input logic [KEY_W-1:0] mul);
        logic [KEY_W-1:0] x;
        x = (k ^ (k >> 16)) * mul;
        x = (x ^ (x >> 16)) * mul;
        x = x ^ (x >> 16);
        return x[IDX_W-1:0];
    endfunction

    // Apply one command to the shadow tables and return the reply it must produce
    function automatic reply_t apply_command(input request_t req);
        reply_t           rsp;
        logic [KEY_W-1:0] held;
        logic [KEY_W-1:0] evicted;
        logic [IDX_W-1:0] ia;
        logic [IDX_W-1:0] ib;
        logic             hit_a;
        logic             hit_b;
        logic             placed;
        int               rounds;
        rsp.status = STAT_MISS;
        rsp.dropped = '0;
        ia = slot_hash(req.key, MIX_A);
        ib = slot_hash(req.key, MIX_B);
        hit_a = shadow_valid[0][ia] && shadow_key[0][ia] == req.key;
        hit_b = shadow_valid[1][ib] && shadow_key[1][ib] == req.key;
        case (req.cmd)
            CMD_INSERT:
            begin
                if (hit_a || hit_b)
                    rsp.status = STAT_OK;
                else
                begin
                    // Walk the eviction chain: each round tries the first table,
                    // then pushes the displaced key into the second table.
                    held = req.key;
                    placed = 1'b0;
                    rounds = 0;
                    while (!placed && rounds < kick_limit)
                    begin
                        ia = slot_hash(held, MIX_A);
                        placed = !shadow_valid[0][ia];
                        evicted = shadow_key[0][ia];
                        shadow_key[0][ia] = held;
                        shadow_valid[0][ia] = 1'b1;
                        if (!placed)
                        begin
                            held = evicted;
                            ib = slot_hash(held, MIX_B);
                            placed = !shadow_valid[1][ib];
                            evicted = shadow_key[1][ib];
                            shadow_key[1][ib] = held;
                            shadow_valid[1][ib] = 1'b1;
                            held = evicted;
                        end
                        rounds++;
                    end
                    if (placed)
                        rsp.status = STAT_OK;
                    else
                    begin
                        rsp.status = STAT_FULL;
                        rsp.dropped = held;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (hit_a)
                begin
                    shadow_valid[0][ia] = 1'b0;
                    rsp.status = STAT_OK;
                end
                else if (hit_b)
                begin
                    shadow_valid[1][ib] = 1'b0;
                    rsp.status = STAT_OK;
                end
            end
            CMD_LOOKUP:
                rsp.status = (hit_a || hit_b) ? STAT_OK : STAT_MISS;
            default: ;
        endcase
        return rsp;
    endfunction

    // Watch both streams and the register channel at the rising edge.
    // Check the reply side first so an older result is never matched against
    // a command accepted in the same cycle.
    always @(posedge clk)
    begin : watch
        reply_t   got;
        reply_t   want;
        request_t req;
        logic     moved;
        moved = 1'b0;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                got.status = m_axis_tuser;
                got.dropped = m_axis_tdata;
                replies_seen++;
                status_count[got.status]++;
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: reply with nothing expected: status %0d dropped %h",
                             $time, got.status, got.dropped);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        mismatches++;
                        $display("%0t: dropped_key expected %h, actual %h",
                                 $time, want.dropped, got.dropped);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                req_taken = 1'b1;
                req.cmd = s_axis_tuser;
                req.key = s_axis_tdata;
                cmd_count[req.cmd]++;
                pending_replies.push_back(apply_command(req));
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Command driver: hold the offered command until its transfer, then advance
    // to the next one or idle.
    always @(negedge clk)
    begin : feed
        request_t next_req;
        logic     offer;
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            offer = pending_requests.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT);
            if (offer)
            begin
                next_req = pending_requests.pop_front();
                s_axis_tdata <= next_req.key;
                s_axis_tuser <= next_req.cmd;
            end
            s_axis_tvalid <= offer;
        end
    end

    // Reply sink: random stalls, plus one long hold-off partway through so the
    // output register and the sequencer back up and the command side stalls.
    always @(negedge clk)
    begin : sink
        if (hold_left != 0)
            hold_left--;
        else if (!hold_done && replies_seen >= HOLD_AT)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        m_axis_tready <= hold_left == 0 && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Drain everything queued and in flight, then let the sequencer settle
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || s_axis_tvalid || pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_kicks(input logic [KICK_W-1:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        kick_limit = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
        request_t req;
        req.cmd = cmd;
        req.key = key;
        pending_requests.push_back(req);
    endtask

    // Mostly full-range keys, with some crowded at both ends of the range
    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(9))
            0: return $urandom_range(255);
            1: return ~$urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // A different key that lands on the same first-table slot
    function automatic logic [KEY_W-1:0] first_twin(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] c;
        c = k;
        while (c == k || slot_hash(c, MIX_A) != slot_hash(k, MIX_A))
            c = $urandom;
        return c;
    endfunction

    // Random traffic over a pool of live keys so removes and lookups mostly hit
    // and inserts build chains of evictions; the reserved code is the noise.
    task automatic queue_traffic(input int count);
        int               roll;
        int               pick;
        logic             use_live;
        logic [1:0]       cmd;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                cmd = CMD_NONE;
            else if (roll < 45)
                cmd = live_keys.size() < POOL_CAP ? CMD_INSERT : CMD_REMOVE;
            else if (roll < 72)
                cmd = CMD_REMOVE;
            else
                cmd = CMD_LOOKUP;
            pick = live_keys.size() != 0 ? $urandom_range(live_keys.size() - 1) : 0;
            use_live = live_keys.size() != 0 &&
                       $urandom_range(99) < (cmd == CMD_INSERT ? 25 : 75);
            k = use_live ? live_keys[pick] : fresh_key();
            if (cmd == CMD_INSERT && !use_live)
                live_keys.push_back(k);
            if (cmd == CMD_REMOVE && use_live)
                live_keys.delete(pick);
            if (cmd == CMD_NONE)
                k = $urandom;
            queue_request(cmd, k);
        end
    endtask

    initial
    begin : run
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_c;
        logic [KEY_W-1:0] absent;
        for (int t = 0; t < 2; t++)
            for (int s = 0; s < SLOTS; s++)
            begin
                shadow_key[t][s] = '0;
                shadow_valid[t][s] = 1'b0;
            end
        kick_limit = KICKS_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit: extreme keys, repeat insert, misses,
        // the reserved code, and keys pushed into the second table by collision.
        key_a = $urandom;
        key_b = first_twin(key_a);
        key_c = first_twin(key_a);
        absent = 32'h1357_9bdf;
        queue_request(CMD_INSERT, 32'h0000_0000);
        queue_request(CMD_INSERT, 32'hffff_ffff);
        queue_request(CMD_LOOKUP, 32'h0000_0000);
        queue_request(CMD_LOOKUP, 32'hffff_ffff);
        queue_request(CMD_INSERT, 32'h0000_0000);
        queue_request(CMD_LOOKUP, absent);
        queue_request(CMD_REMOVE, absent);
        queue_request(CMD_REMOVE, 32'h0000_0000);
        queue_request(CMD_LOOKUP, 32'h0000_0000);
        queue_request(CMD_NONE, 32'hffff_ffff);
        queue_request(CMD_NONE, 32'h0000_0000);
        queue_request(CMD_INSERT, key_a);
        queue_request(CMD_INSERT, key_b);
        queue_request(CMD_LOOKUP, key_a);
        queue_request(CMD_LOOKUP, key_b);
        queue_request(CMD_INSERT, key_c);
        queue_request(CMD_LOOKUP, key_a);
        queue_request(CMD_LOOKUP, key_b);
        queue_request(CMD_LOOKUP, key_c);
        queue_request(CMD_REMOVE, key_a);
        queue_request(CMD_REMOVE, key_b);
        queue_request(CMD_REMOVE, key_c);
        queue_request(CMD_LOOKUP, key_b);
        queue_request(CMD_REMOVE, 32'hffff_ffff);

        // Random phases, each under its own eviction limit; the phase at the
        // reset limit runs with no idling on either side.
        for (int p = 0; p < PHASES; p++)
        begin
            write_kicks(KICK_W'(phase_kicks[p]));
            calm = phase_kicks[p] == KICKS_RESET;
            queue_traffic(phase_items[p]);
        end

        wait_quiet();
        if (pending_replies.size() != 0)
            mismatches++;

        $display("Ran %0d inserts, %0d removes, %0d lookups, %0d reserved codes over %0d limits",
                 cmd_count[CMD_INSERT], cmd_count[CMD_REMOVE], cmd_count[CMD_LOOKUP],
                 cmd_count[CMD_NONE], cfg_writes + 1);
        $display("Replies: %0d success, %0d not found, %0d table full; %0d mismatches",
                 status_count[STAT_OK], status_count[STAT_MISS], status_count[STAT_FULL],
                 mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
src/chks_pkg.sv
src/chks_hash.sv
src/chks_table.sv
src/cuckoo_hash_key_set.sv
test/tb_top.sv
